>>> design/fdsl_pkg.sv
// Shared constants for the fan duty slew limiter.
package fdsl_pkg;

   localparam int LEVEL_W     = 8;
   localparam int SUM_W       = 10;
   localparam int MAG_W       = 18;
   localparam int RECIP_W     = 19;
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = 3;

   localparam int COLOUR_SPAN = 765;
   localparam int RECIP_SHIFT = 28;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + COLOUR_SPAN - 1) / COLOUR_SPAN);

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_COLOUR = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_MIN_SPEED = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ZERO_RPM  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STEP_UP   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STEP_DOWN = 3'd4;

   localparam logic [LEVEL_W-1:0] MIN_SPEED_RST = 8'd40;
   localparam logic [LEVEL_W-1:0] MAX_SPEED_RST = 8'd255;
   localparam logic               ZERO_RPM_RST  = 1'b0;
   localparam logic [LEVEL_W-1:0] STEP_UP_RST   = 8'd5;
   localparam logic [LEVEL_W-1:0] STEP_DOWN_RST = 8'd1;

endpackage

>>> design/fan_duty_slew_limiter.sv
// Fan duty slew limiter: colour-to-target mapping and ramped PWM duty, with CSR port.
// Takes one item per clock while results are taken and gives one result per item: the
// input register loads when the item is accepted, then the product register, then the
// result register. The depth is set by the color path: the byte sum times the speed
// span is registered, then divided by 765 through a reciprocal multiply ahead of the
// result register; ticks ride the same stages so that every item sees the target and
// current speed that the item before it left. A stalled result holds the stages behind
// it, and input is refused only once all three registers are full. Target and current
// speed reset to 0; CSR writes take effect at the access phase, pready is always high,
// and registers are meant to be changed only while no item is in flight.
module fan_duty_slew_limiter
   import fdsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [LEVEL_W-1:0]    req_red,
   input  logic [LEVEL_W-1:0]    req_green,
   input  logic [LEVEL_W-1:0]    req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEVEL_W-1:0]    rsp_duty,
   output logic                  rsp_duty_written,
   output logic [LEVEL_W-1:0]    rsp_target_level,
   output logic [LEVEL_W-1:0]    rsp_current_level,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration
   logic [LEVEL_W-1:0] min_speed_ff, min_speed_in;
   logic [LEVEL_W-1:0] max_speed_ff, max_speed_in;
   logic               zero_rpm_ff, zero_rpm_in;
   logic [LEVEL_W-1:0] step_up_ff, step_up_in;
   logic [LEVEL_W-1:0] step_down_ff, step_down_in;

   // speed state
   logic [LEVEL_W-1:0] target_level_ff, target_level_in;
   logic [LEVEL_W-1:0] current_level_ff, current_level_in;

   // stage 1: input register
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_cmd_ff, s1_cmd_in;
   logic [LEVEL_W-1:0] s1_red_ff, s1_red_in;
   logic [LEVEL_W-1:0] s1_green_ff, s1_green_in;
   logic [LEVEL_W-1:0] s1_blue_ff, s1_blue_in;

   // stage 2: product register
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_cmd_ff, s2_cmd_in;
   logic [MAG_W-1:0]   s2_mag_ff, s2_mag_in;
   logic               s2_neg_ff, s2_neg_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic               rsp_written_ff, rsp_written_in;
   logic [LEVEL_W-1:0] rsp_target_ff, rsp_target_in;
   logic [LEVEL_W-1:0] rsp_current_ff, rsp_current_in;

   logic                 out_ready;
   logic                 s2_ready;
   logic                 s2_fire;
   logic                 req_fire;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_idx;
   logic [SUM_W-1:0]     sum;
   logic                 span_neg;
   logic [LEVEL_W-1:0]   span_mag;
   logic [PROD_W-1:0]    prod;
   logic [LEVEL_W-1:0]   quot;
   logic [LEVEL_W-1:0]   new_target;
   logic [LEVEL_W-1:0]   ramp_level;
   logic                 ramp_move;
   logic [LEVEL_W-1:0]   floored;

   // handshake and stage advance
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign req_fire  = req_valid && req_ready;
   assign s2_fire   = s2_valid_ff && out_ready;

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      min_speed_in = min_speed_ff;
      max_speed_in = max_speed_ff;
      zero_rpm_in  = zero_rpm_ff;
      step_up_in   = step_up_ff;
      step_down_in = step_down_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_MIN_SPEED: min_speed_in = csr_pwdata[LEVEL_W-1:0];
            REG_MAX_SPEED: max_speed_in = csr_pwdata[LEVEL_W-1:0];
            REG_ZERO_RPM:  zero_rpm_in  = csr_pwdata[0];
            REG_STEP_UP:   step_up_in   = csr_pwdata[LEVEL_W-1:0];
            REG_STEP_DOWN: step_down_in = csr_pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MIN_SPEED: csr_prdata = CSR_DATA_W'(min_speed_ff);
         REG_MAX_SPEED: csr_prdata = CSR_DATA_W'(max_speed_ff);
         REG_ZERO_RPM:  csr_prdata = CSR_DATA_W'(zero_rpm_ff);
         REG_STEP_UP:   csr_prdata = CSR_DATA_W'(step_up_ff);
         REG_STEP_DOWN: csr_prdata = CSR_DATA_W'(step_down_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // stage 1 -> 2: byte sum times span magnitude
   assign sum      = SUM_W'(s1_red_ff) + SUM_W'(s1_green_ff) + SUM_W'(s1_blue_ff);
   assign span_neg = max_speed_ff < min_speed_ff;
   assign span_mag = span_neg ? (min_speed_ff - max_speed_ff) : (max_speed_ff - min_speed_ff);

   always_comb begin
      s1_valid_in = req_fire ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);
      s1_cmd_in   = req_fire ? req_cmd   : s1_cmd_ff;
      s1_red_in   = req_fire ? req_red   : s1_red_ff;
      s1_green_in = req_fire ? req_green : s1_green_ff;
      s1_blue_in  = req_fire ? req_blue  : s1_blue_ff;

      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_cmd_in   = s2_ready ? s1_cmd_ff : s2_cmd_ff;
      s2_mag_in   = s2_ready ? (MAG_W'(sum) * MAG_W'(span_mag)) : s2_mag_ff;
      s2_neg_in   = s2_ready ? span_neg : s2_neg_ff;
   end

   // stage 2 -> result: divide by 765, ramp, floor rule
   assign prod       = PROD_W'(s2_mag_ff) * PROD_W'(RECIP);
   assign quot       = prod[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
   assign new_target = s2_neg_ff ? (min_speed_ff - quot) : (min_speed_ff + quot);
   assign floored    = (ramp_level <= min_speed_ff) ? (zero_rpm_ff ? '0 : min_speed_ff)
                                                    : ramp_level;

   always_comb begin
      ramp_level = current_level_ff;
      ramp_move  = 1'b0;
      if (current_level_ff < target_level_ff) begin
         ramp_move  = 1'b1;
         ramp_level = ((target_level_ff - current_level_ff) < step_up_ff)
                      ? target_level_ff : (current_level_ff + step_up_ff);
      end else if (current_level_ff > target_level_ff) begin
         ramp_move  = 1'b1;
         ramp_level = ((current_level_ff - target_level_ff) < step_down_ff)
                      ? target_level_ff : (current_level_ff - step_down_ff);
      end
   end

   always_comb begin
      target_level_in  = target_level_ff;
      current_level_in = current_level_ff;
      rsp_valid_in     = out_ready ? s2_valid_ff : rsp_valid_ff;
      rsp_duty_in      = rsp_duty_ff;
      rsp_written_in   = rsp_written_ff;
      rsp_target_in    = rsp_target_ff;
      rsp_current_in   = rsp_current_ff;
      if (s2_fire) begin
         if (s2_cmd_ff == CMD_COLOUR) begin
            target_level_in = new_target;
            rsp_duty_in     = '0;
            rsp_written_in  = 1'b0;
         end else begin
            current_level_in = ramp_level;
            rsp_duty_in      = ramp_move ? floored : '0;
            rsp_written_in   = ramp_move;
         end
         rsp_target_in  = target_level_in;
         rsp_current_in = current_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_ff     <= MIN_SPEED_RST;
         max_speed_ff     <= MAX_SPEED_RST;
         zero_rpm_ff      <= ZERO_RPM_RST;
         step_up_ff       <= STEP_UP_RST;
         step_down_ff     <= STEP_DOWN_RST;
         target_level_ff  <= '0;
         current_level_ff <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         min_speed_ff     <= min_speed_in;
         max_speed_ff     <= max_speed_in;
         zero_rpm_ff      <= zero_rpm_in;
         step_up_ff       <= step_up_in;
         step_down_ff     <= step_down_in;
         target_level_ff  <= target_level_in;
         current_level_ff <= current_level_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff      <= s1_cmd_in;
      s1_red_ff      <= s1_red_in;
      s1_green_ff    <= s1_green_in;
      s1_blue_ff     <= s1_blue_in;
      s2_cmd_ff      <= s2_cmd_in;
      s2_mag_ff      <= s2_mag_in;
      s2_neg_ff      <= s2_neg_in;
      rsp_duty_ff    <= rsp_duty_in;
      rsp_written_ff <= rsp_written_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_current_ff <= rsp_current_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty          = rsp_duty_ff;
   assign rsp_duty_written  = rsp_written_ff;
   assign rsp_target_level  = rsp_target_ff;
   assign rsp_current_level = rsp_current_ff;

   // a pending result always shows the speed state it left behind
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_target_ff == target_level_ff) && (rsp_current_ff == current_level_ff))
      else $error("pending result disagrees with speed state");

   a_no_duty_unwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_written_ff) |-> (rsp_duty_ff == '0))
      else $error("duty nonzero without a write");

   a_current_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !s2_fire |=> $stable(current_level_ff) && $stable(target_level_ff))
      else $error("speed state changed without an item");

   a_s2_item_held: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_ready) |=> s2_valid_ff)
      else $error("stalled item dropped from product stage");

endmodule
